FILE: hdl/srsd_pkg.sv
// ----------------------------------------------------------------------------
// srsd_pkg: shared types and decode helpers for the stitch record decoder
// Stitch kind codes, result word layout and balanced-ternary weight helpers.
// ----------------------------------------------------------------------------
package srsd_pkg;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_TRIM   = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  // Byte position within a record
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  // Third byte codes
  localparam logic [7:0] END_CODE  = 8'hF3;
  localparam logic [7:0] KIND_MASK = 8'hC3;
  localparam logic [7:0] TRIM_CODE = 8'h83;
  localparam logic [7:0] STOP_CODE = 8'hC3;

  // Balanced-ternary weights
  localparam logic signed [7:0] W1  = 8'sd1;
  localparam logic signed [7:0] W3  = 8'sd3;
  localparam logic signed [7:0] W9  = 8'sd9;
  localparam logic signed [7:0] W27 = 8'sd27;
  localparam logic signed [7:0] W81 = 8'sd81;

  // Output queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef struct packed {
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    kind_t             kind;
    logic              last;
  } result_t;

  function automatic kind_t kind_of(input logic [7:0] t);
    kind_t k;
    k = KIND_NORMAL;
    if (t == END_CODE) begin
      k = KIND_END;
    end else if ((t & KIND_MASK) == TRIM_CODE) begin
      k = KIND_TRIM;
    end else if ((t & KIND_MASK) == STOP_CODE) begin
      k = KIND_STOP;
    end
    return k;
  endfunction

  // +w if pos bit set, -w if neg bit set, both cancel
  function automatic logic signed [7:0] tern(input logic pos, input logic neg,
                                             input logic signed [7:0] w);
    logic signed [7:0] r;
    r = 8'sd0;
    if (pos) r = r + w;
    if (neg) r = r - w;
    return r;
  endfunction

endpackage

FILE: hdl/stitch_record_stream_decoder.sv
// ----------------------------------------------------------------------------
// stitch_record_stream_decoder
// Groups a byte stream into 3-byte balanced-ternary stitch records.
// ----------------------------------------------------------------------------
// The decoder takes one file byte per cycle while the queue has room and
// emits one result word per completed 3-byte record, carrying the relative
// x/y move in tenths of a millimetre (-121..121) and the stitch kind
// (normal, trim, stop, end). Bytes after an end record are dropped until
// the byte flagged stream_end. A byte flagged stream_end closes the stream:
// a partial record is dropped, a zero-move end word is appended when no end
// record was seen, and all record state returns to its reset value. run_last
// marks the final word caused by a byte. Decode is a single shallow pass
// from the record holding registers into a 4-entry result queue; a byte is
// taken whenever the queue has room for two words, so with the result side
// ready every cycle the decoder sustains one byte per cycle, and each word
// is registered in the queue. A byte that yields two words needs an extra
// output slot, which the queue absorbs.
// ----------------------------------------------------------------------------
module stitch_record_stream_decoder
  import srsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_stream_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] out_move_x,
  output logic signed [7:0] out_move_y,
  output logic [1:0]        out_stitch_kind,
  output logic              out_run_last
);

  // Record state
  logic [1:0] pos_r,   pos_nxt;
  logic [7:0] b0_r,    b0_nxt;
  logic [7:0] b1_r,    b1_nxt;
  logic       end_r,   end_nxt;

  // Result queue
  result_t              q_r [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r,    cnt_nxt;

  logic       in_acc, out_acc;
  logic       rec_vld, eos_vld;
  logic [1:0] n_push;
  kind_t      rec_kind;
  logic signed [7:0] rec_x, rec_y;
  result_t    res0, res1;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign in_ready = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_acc  = out_valid && out_ready;

  // Decode the record completed by the incoming byte
  always_comb begin
    rec_kind = kind_of(in_data_byte);
    rec_x = tern(b0_r[0], b0_r[1], W1) + tern(b0_r[2], b0_r[3], W9)
          + tern(b1_r[0], b1_r[1], W3) + tern(b1_r[2], b1_r[3], W27)
          + tern(in_data_byte[2], in_data_byte[3], W81);
    rec_y = tern(b0_r[7], b0_r[6], W1) + tern(b0_r[5], b0_r[4], W9)
          + tern(b1_r[7], b1_r[6], W3) + tern(b1_r[5], b1_r[4], W27)
          + tern(in_data_byte[5], in_data_byte[4], W81);
  end

  // Next record state and the words this byte produces
  always_comb begin
    pos_nxt = pos_r;
    b0_nxt  = b0_r;
    b1_nxt  = b1_r;
    end_nxt = end_r;
    rec_vld = 1'b0;
    eos_vld = 1'b0;
    if (in_acc) begin
      if (!end_r) begin
        case (pos_r)
          POS_FIRST: begin
            b0_nxt  = in_data_byte;
            pos_nxt = POS_SECOND;
          end
          POS_SECOND: begin
            b1_nxt  = in_data_byte;
            pos_nxt = POS_THIRD;
          end
          POS_THIRD: begin
            rec_vld = 1'b1;
            pos_nxt = POS_FIRST;
            if (rec_kind == KIND_END) end_nxt = 1'b1;
          end
          default: begin
            pos_nxt = POS_FIRST;
          end
        endcase
      end
      if (in_stream_end) begin
        // Close the stream: append end word if none seen, then clear
        eos_vld = !end_nxt;
        pos_nxt = POS_FIRST;
        b0_nxt  = '0;
        b1_nxt  = '0;
        end_nxt = 1'b0;
      end
    end
  end

  assign n_push = {1'b0, rec_vld} + {1'b0, eos_vld};

  // Slot 0 takes the record word if any, else the end word; slot 1 the end word
  always_comb begin
    res0.move_x = rec_vld ? rec_x : 8'sd0;
    res0.move_y = rec_vld ? rec_y : 8'sd0;
    res0.kind   = rec_vld ? rec_kind : KIND_END;
    res0.last   = (n_push == 2'd1);
    res1.move_x = 8'sd0;
    res1.move_y = 8'sd0;
    res1.kind   = KIND_END;
    res1.last   = 1'b1;
  end

  assign wr_ptr_p1  = wr_ptr_r + PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(out_acc);
  assign cnt_nxt    = cnt_r + CNT_W'(n_push) - CNT_W'(out_acc);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_FIRST;
      b0_r     <= '0;
      b1_r     <= '0;
      end_r    <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      b0_r     <= b0_nxt;
      b1_r     <= b1_nxt;
      end_r    <= end_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_p1] <= res1;
    end
  end

  assign out_move_x      = q_r[rd_ptr_r].move_x;
  assign out_move_y      = q_r[rd_ptr_r].move_y;
  assign out_stitch_kind = q_r[rd_ptr_r].kind;
  assign out_run_last    = q_r[rd_ptr_r].last;

  // Queue never overflows
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // A closing byte always leaves clean record state
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_stream_end) |=> (pos_r == POS_FIRST && !end_r))
    else $error("state not cleared after stream end");

  // Once an end record is seen, no partial record is held
  assert property (@(posedge clk) disable iff (!rst_n)
    end_r |-> (pos_r == POS_FIRST))
    else $error("partial record held after end record");

  // Record position stays within a record
  assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 2'd3)
    else $error("record position out of range");

endmodule
